@@ rtl/hcmbd_pkg.sv @@
// Package for the handheld console memory bus decoder.
// Holds the transfer structs, target and region codes, register indexes and map bounds.
// No dependencies.
package hcmbd_pkg;

    // Default number of 4 KB work RAM banks
    localparam int HCMBD_WORK_BANKS = 8;

    // Configuration register indexes
    localparam logic CFG_COLOR_MODE = 1'b0;
    localparam logic CFG_BOOT_SIZE  = 1'b1;

    // Reset value of the boot overlay size
    localparam logic [12:0] BOOT_SIZE_RESET = 13'd256;

    // Address map bounds
    localparam logic [15:0] CART_LO_END   = 16'h7FFF;
    localparam logic [15:0] VIDEO_START   = 16'h8000;
    localparam logic [15:0] VIDEO_END     = 16'h9FFF;
    localparam logic [15:0] CART_HI_START = 16'hA000;
    localparam logic [15:0] CART_HI_END   = 16'hBFFF;
    localparam logic [15:0] WORK_START    = 16'hC000;
    localparam logic [15:0] WORK_UP_START = 16'hD000;
    localparam logic [15:0] WORK_END      = 16'hDFFF;
    localparam logic [15:0] ECHO_START    = 16'hE000;
    localparam logic [15:0] ECHO_END      = 16'hFDFF;
    localparam logic [15:0] ECHO_FOLD     = 16'h2000;
    localparam logic [15:0] OBJECT_START  = 16'hFE00;
    localparam logic [15:0] OBJECT_END    = 16'hFE9F;
    localparam logic [15:0] IO_START      = 16'hFF00;
    localparam logic [15:0] IO_END        = 16'hFF7F;
    localparam logic [15:0] HIGH_START    = 16'hFF80;
    localparam logic [15:0] HIGH_END      = 16'hFFFE;
    localparam logic [15:0] IE_ADDR       = 16'hFFFF;

    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // Store depths
    localparam int VIDEO_DEPTH  = 16384;
    localparam int OBJECT_DEPTH = 160;
    localparam int HIGH_DEPTH   = 127;
    localparam int BANK_BYTES   = 4096;

    typedef enum logic [1:0] {
        TGT_LOCAL = 2'd0,
        TGT_CART  = 2'd1,
        TGT_IO    = 2'd2,
        TGT_BOOT  = 2'd3
    } t_target;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_VIDEO,
        REG_WORK,
        REG_OBJECT,
        REG_HIGH,
        REG_IE
    } t_region;

    typedef struct packed {
        logic       op;
        logic [15:0] address;
        logic [7:0] write_data;
        logic       video_bank;
        logic [2:0] work_bank;
        logic       boot_active;
    } t_bus_req;

    typedef struct packed {
        logic [7:0]  read_data;
        t_target     forward_target;
        logic [15:0] forward_address;
        logic        forward_write;
        logic [7:0]  forward_data;
        logic        irq_recheck;
    } t_bus_rsp;

    // Access command from the decoder to the local stores
    typedef struct packed {
        logic        valid;
        logic        wr;
        t_region     region;
        logic [15:0] addr;
        logic        vbank;
        logic [2:0]  wbank;
        logic [7:0]  data;
    } t_ram_cmd;

endpackage

@@ rtl/handheld_console_memory_bus_decoder.sv @@
// One access is accepted every cycle and busy stays low; the result strobe comes
// from the result register, and the result transfers with that strobe.
// Stages: input register, decode plus store access, result register.
// Reset clears the pipeline valids, the configuration and the interrupt-enable byte;
// the local RAMs are not cleared and read unspecified data until written.
// Depends on hcmbd_pkg and hcmbd_local_ram.
module handheld_console_memory_bus_decoder import hcmbd_pkg::*; #(
    parameter int WORK_BANKS = HCMBD_WORK_BANKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_bus_req    i_req,
    output logic        o_valid,
    output t_bus_rsp    o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    logic        r_color_mode;
    logic [12:0] r_boot_size;

    logic        r_s1_valid;
    t_bus_req    r_s1_req;

    logic        r_s2_valid;
    t_target     r_s2_target;
    logic [15:0] r_s2_addr;
    logic        r_s2_wr;
    logic [7:0]  r_s2_data;
    logic        r_s2_irq;
    logic        r_s2_local_rd;

    logic        r_out_valid;
    t_bus_rsp    r_out;

    t_target     n_target;
    t_ram_cmd    ram_cmd;
    logic [15:0] fold_addr;
    logic [2:0]  bank;
    logic [7:0]  ram_rd;
    t_bus_rsp    n_out;

    assign busy = 1'b0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_boot_size  <= BOOT_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                CFG_BOOT_SIZE:  r_boot_size  <= i_cfg_data;
                default:        r_boot_size  <= r_boot_size;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_req <= i_req;
    end

    // Route the access: boot overlay, cartridge, I/O or local
    always_comb begin
        priority if (!r_s1_req.op && r_s1_req.boot_active
                     && r_s1_req.address < {3'b000, r_boot_size}) begin
            n_target = TGT_BOOT;
        end else if (r_s1_req.address <= CART_LO_END
                     || (r_s1_req.address >= CART_HI_START
                         && r_s1_req.address <= CART_HI_END)) begin
            n_target = TGT_CART;
        end else if (r_s1_req.address >= IO_START && r_s1_req.address <= IO_END) begin
            n_target = TGT_IO;
        end else begin
            n_target = TGT_LOCAL;
        end
    end

    // Fold echo RAM and pick the upper work RAM bank
    always_comb begin
        fold_addr = r_s1_req.address;
        if (r_s1_req.address >= ECHO_START && r_s1_req.address <= ECHO_END) begin
            fold_addr = r_s1_req.address - ECHO_FOLD;
        end
        bank = 3'd1;
        if (r_color_mode) begin
            bank = r_s1_req.work_bank;
            if (bank == 3'd0) begin
                bank = 3'd1;
            end
            if (32'(bank) >= WORK_BANKS) begin
                bank = 3'(WORK_BANKS - 1);
            end
        end
    end

    // Build the store command
    always_comb begin
        ram_cmd.valid = r_s1_valid && n_target == TGT_LOCAL;
        ram_cmd.wr    = r_s1_req.op;
        ram_cmd.addr  = fold_addr;
        ram_cmd.vbank = r_s1_req.video_bank;
        ram_cmd.data  = r_s1_req.write_data;
        ram_cmd.wbank = 3'd0;
        priority if (n_target != TGT_LOCAL) begin
            ram_cmd.region = REG_NONE;
        end else if (r_s1_req.address == IE_ADDR) begin
            ram_cmd.region = REG_IE;
        end else if (fold_addr >= VIDEO_START && fold_addr <= VIDEO_END) begin
            ram_cmd.region = REG_VIDEO;
        end else if (fold_addr >= WORK_START && fold_addr < WORK_UP_START) begin
            ram_cmd.region = REG_WORK;
        end else if (fold_addr >= WORK_UP_START && fold_addr <= WORK_END) begin
            ram_cmd.region = REG_WORK;
            ram_cmd.wbank  = bank;
        end else if (fold_addr >= OBJECT_START && fold_addr <= OBJECT_END) begin
            ram_cmd.region = REG_OBJECT;
        end else if (fold_addr >= HIGH_START && fold_addr <= HIGH_END) begin
            ram_cmd.region = REG_HIGH;
        end else begin
            ram_cmd.region = REG_NONE;
        end
    end

    hcmbd_local_ram #(
        .WORK_BANKS (WORK_BANKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ram_cmd),
        .o_rd_data (ram_rd)
    );

    // Carry the routing result alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_target   <= n_target;
        r_s2_addr     <= r_s1_req.address;
        r_s2_wr       <= r_s1_req.op;
        r_s2_data     <= r_s1_req.write_data;
        r_s2_irq      <= ram_cmd.region == REG_IE && r_s1_req.op;
        r_s2_local_rd <= ram_cmd.region != REG_NONE && !r_s1_req.op;
    end

    // Assemble the result
    always_comb begin
        n_out.read_data       = r_s2_local_rd ? ram_rd : OPEN_BUS;
        n_out.forward_target  = r_s2_target;
        n_out.forward_address = (r_s2_target != TGT_LOCAL) ? r_s2_addr : 16'd0;
        n_out.forward_write   = r_s2_target != TGT_LOCAL && r_s2_wr;
        n_out.forward_data    = (r_s2_target != TGT_LOCAL && r_s2_wr) ? r_s2_data : 8'd0;
        n_out.irq_recheck     = r_s2_irq;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2_valid;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

@@ rtl/hcmbd_local_ram.sv @@
// Local stores of the memory bus decoder: video, work, object and high RAM plus
// the interrupt-enable byte. One access per cycle, read data registered.
// Depends on hcmbd_pkg.
module hcmbd_local_ram import hcmbd_pkg::*; #(
    parameter int WORK_BANKS = HCMBD_WORK_BANKS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ram_cmd i_cmd,
    output logic [7:0] o_rd_data
);

    localparam int WB_W       = $clog2(WORK_BANKS);
    localparam int WORK_DEPTH = WORK_BANKS * BANK_BYTES;
    localparam int WA_W       = $clog2(WORK_DEPTH);
    localparam int VA_W       = $clog2(VIDEO_DEPTH);
    localparam int OA_W       = $clog2(OBJECT_DEPTH);
    localparam int HA_W       = $clog2(HIGH_DEPTH);

    logic [7:0] r_video [VIDEO_DEPTH];
    logic [7:0] r_work  [WORK_DEPTH];
    logic [7:0] r_obj   [OBJECT_DEPTH];
    logic [7:0] r_high  [HIGH_DEPTH];
    logic [7:0] r_ie;

    logic [7:0] r_video_q;
    logic [7:0] r_work_q;
    logic [7:0] r_obj_q;
    logic [7:0] r_high_q;
    logic [7:0] r_ie_q;
    t_region    r_sel;

    logic [VA_W-1:0] video_idx;
    logic [WA_W-1:0] work_idx;
    logic [OA_W-1:0] obj_idx;
    logic [HA_W-1:0] high_idx;
    logic            wr_en;

    // Form store indexes from the folded address and banks
    assign video_idx = {i_cmd.vbank, i_cmd.addr[VA_W-2:0]};
    assign work_idx  = WA_W'({i_cmd.wbank[WB_W-1:0], i_cmd.addr[11:0]});
    assign obj_idx   = i_cmd.addr[OA_W-1:0];
    assign high_idx  = i_cmd.addr[HA_W-1:0];
    assign wr_en     = i_cmd.valid && i_cmd.wr;

    // Video RAM
    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.region == REG_VIDEO) begin
            r_video[video_idx] <= i_cmd.data;
        end
        r_video_q <= r_video[video_idx];
    end

    // Work RAM
    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.region == REG_WORK) begin
            r_work[work_idx] <= i_cmd.data;
        end
        r_work_q <= r_work[work_idx];
    end

    // Object RAM
    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.region == REG_OBJECT) begin
            r_obj[obj_idx] <= i_cmd.data;
        end
        r_obj_q <= r_obj[obj_idx];
    end

    // High RAM
    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.region == REG_HIGH) begin
            r_high[high_idx] <= i_cmd.data;
        end
        r_high_q <= r_high[high_idx];
    end

    // Interrupt-enable byte, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie <= '0;
        end else if (wr_en && i_cmd.region == REG_IE) begin
            r_ie <= i_cmd.data;
        end
    end

    // Hold the read selection alongside the registered data
    always_ff @(posedge i_clk) begin
        r_ie_q <= r_ie;
        r_sel  <= i_cmd.region;
    end

    // Pick the byte of the addressed store
    always_comb begin
        unique case (r_sel)
            REG_VIDEO:  o_rd_data = r_video_q;
            REG_WORK:   o_rd_data = r_work_q;
            REG_OBJECT: o_rd_data = r_obj_q;
            REG_HIGH:   o_rd_data = r_high_q;
            REG_IE:     o_rd_data = r_ie_q;
            default:    o_rd_data = OPEN_BUS;
        endcase
    end

endmodule
